// ----- rtl/ncpu_pkg.sv -----
package ncpu_pkg;

	// Instruction opcodes, the low nibble of the first instruction byte.
	typedef enum logic [3:0] {
		OP_LDI_A  = 4'h0,
		OP_LD_A   = 4'h1,
		OP_ADDI   = 4'h2,
		OP_NANDI  = 4'h3,
		OP_CMP    = 4'h4,
		OP_ST_AB  = 4'h5,
		OP_ST_PCB = 4'h6,
		OP_JP     = 4'h7,
		OP_LDI_B  = 4'h8,
		OP_LD_B   = 4'h9,
		OP_ADD_B  = 4'hA,
		OP_NAND_B = 4'hB,
		OP_NCMP   = 4'hC,
		OP_ST_BB  = 4'hD,
		OP_ST_PCH = 4'hE,
		OP_JPC    = 4'hF
	} op_t;

	typedef enum logic [2:0] {
		MEM_NONE,
		MEM_RD_PC,
		MEM_RD_PC1,
		MEM_RD_HIGH,
		MEM_RD_ADR,
		MEM_WR_LOAD,
		MEM_WR_STORE
	} mem_op_t;

	typedef enum logic [1:0] {
		PC_HOLD,
		PC_INC,
		PC_JUMP,
		PC_JUMP_IF_F
	} pc_op_t;

	typedef enum logic [1:0] {
		WB_NONE,
		WB_EXEC,
		WB_MEM_A,
		WB_MEM_B
	} wb_t;

	typedef enum logic [2:0] {
		BR_NEXT,
		BR_WAIT,
		BR_SEL,
		BR_DISPATCH,
		BR_GOTO
	} br_t;

	localparam int STEP_W = 4;
	typedef logic [STEP_W-1:0] step_t;

	// Microprogram addresses.
	localparam step_t U_IDLE    = 4'd0;
	localparam step_t U_SEL     = 4'd1;
	localparam step_t U_SECOND  = 4'd2;
	localparam step_t U_ADR     = 4'd3;
	localparam step_t U_REG     = 4'd4;
	localparam step_t U_LDA     = 4'd5;
	localparam step_t U_LDA_WB  = 4'd6;
	localparam step_t U_LDB     = 4'd7;
	localparam step_t U_LDB_WB  = 4'd8;
	localparam step_t U_STORE   = 4'd9;
	localparam step_t U_JUMP    = 4'd10;
	localparam step_t U_JUMPC   = 4'd11;
	localparam step_t U_LOAD    = 4'd12;

	typedef struct packed {
		mem_op_t mem_op;
		pc_op_t  pc_op;
		wb_t     wb;
		logic    ir_ld;
		logic    adr_ld;
		logic    store;
		logic    done;
		br_t     br;
		step_t   target;
	} ctrl_t;

	localparam ctrl_t CTRL_NOP = '0;

	typedef struct packed {
		logic is_load;
		logic long_instr;
		op_t  op;
	} stat_t;

	typedef struct packed {
		logic       re;
		logic       we;
		logic [7:0] addr;
		logic [7:0] wdata;
	} mem_req_t;

	typedef struct packed {
		logic [3:0]  reg_a;
		logic [3:0]  reg_b;
		logic [11:0] program_counter;
		logic        cond_flag;
		logic        store_valid;
		logic [7:0]  store_address;
		logic [7:0]  store_data;
	} res_t;

	// Opcodes whose low three bits are 1, 5, 6 or 7 carry a second byte.
	function automatic logic is_long(input logic [3:0] op);
		logic r;
		begin
			case (op[2:0]) inside
				3'd1, 3'd5, 3'd6, 3'd7: r = 1'b1;
				default:                r = 1'b0;
			endcase
			return r;
		end
	endfunction

	function automatic step_t dispatch(input op_t op);
		step_t s;
		begin
			case (op)
				OP_LD_A:   s = U_LDA;
				OP_LD_B:   s = U_LDB;
				OP_ST_AB,
				OP_ST_PCB,
				OP_ST_BB,
				OP_ST_PCH: s = U_STORE;
				OP_JP:     s = U_JUMP;
				OP_JPC:    s = U_JUMPC;
				default:   s = U_REG;
			endcase
			return s;
		end
	endfunction

	// Control store: one word per microprogram step.
	function automatic ctrl_t ucode(input step_t s);
		ctrl_t c;
		begin
			c = CTRL_NOP;
			c.br = BR_GOTO;
			c.target = U_IDLE;
			case (s)
				U_IDLE: begin
					c.mem_op = MEM_RD_PC;
					c.br = BR_WAIT;
				end
				U_SEL: begin
					c.ir_ld = 1'b1;
					c.br = BR_SEL;
				end
				U_SECOND: begin
					c.mem_op = MEM_RD_PC1;
					c.pc_op = PC_INC;
					c.br = BR_NEXT;
				end
				U_ADR: begin
					c.adr_ld = 1'b1;
					c.br = BR_DISPATCH;
				end
				U_REG: begin
					c.wb = WB_EXEC;
					c.pc_op = PC_INC;
					c.done = 1'b1;
				end
				U_LDA: begin
					c.mem_op = MEM_RD_HIGH;
					c.br = BR_NEXT;
				end
				U_LDA_WB: begin
					c.wb = WB_MEM_A;
					c.pc_op = PC_INC;
					c.done = 1'b1;
				end
				U_LDB: begin
					c.mem_op = MEM_RD_ADR;
					c.br = BR_NEXT;
				end
				U_LDB_WB: begin
					c.wb = WB_MEM_B;
					c.pc_op = PC_INC;
					c.done = 1'b1;
				end
				U_STORE: begin
					c.mem_op = MEM_WR_STORE;
					c.store = 1'b1;
					c.pc_op = PC_INC;
					c.done = 1'b1;
				end
				U_JUMP: begin
					c.pc_op = PC_JUMP;
					c.done = 1'b1;
				end
				U_JUMPC: begin
					c.pc_op = PC_JUMP_IF_F;
					c.done = 1'b1;
				end
				U_LOAD: begin
					c.mem_op = MEM_WR_LOAD;
					c.done = 1'b1;
				end
				default: begin
					c.br = BR_GOTO;
				end
			endcase
			return c;
		end
	endfunction

endpackage

// ----- rtl/ncpu_chan_if.sv -----
interface ncpu_in_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] load_address;
	logic [7:0] load_data;

	modport source(output valid, opcode, load_address, load_data, input ready);
	modport sink(input valid, opcode, load_address, load_data, output ready);
endinterface

interface ncpu_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  reg_a;
	logic [3:0]  reg_b;
	logic [11:0] program_counter;
	logic        cond_flag;
	logic        store_valid;
	logic [7:0]  store_address;
	logic [7:0]  store_data;

	modport source(output valid, reg_a, reg_b, program_counter, cond_flag, store_valid,
		store_address, store_data, input ready);
	modport sink(input valid, reg_a, reg_b, program_counter, cond_flag, store_valid,
		store_address, store_data, output ready);
endinterface

// ----- rtl/ncpu_mem.sv -----
module ncpu_mem #(
	parameter int DEPTH = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ncpu_pkg::mem_req_t req,
	output logic [7:0]         rdata
);
	import ncpu_pkg::*;

	localparam int AW = $clog2(DEPTH);

	logic [7:0]       mem_q [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [7:0]       rdata_q;
	logic [AW-1:0]    addr;

	assign addr = req.addr[AW-1:0];

	// An entry never written reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (req.we) begin
			vld_q[addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[addr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata_q <= vld_q[addr] ? mem_q[addr] : 8'h00;
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/ncpu_seq.sv -----
module ncpu_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_accept,
	input  ncpu_pkg::stat_t stat,
	input  logic            out_block,
	output logic            in_ready,
	output ncpu_pkg::ctrl_t ctrl
);
	import ncpu_pkg::*;

	step_t step_q;
	step_t step_d;
	ctrl_t cw;
	logic  stall;

	assign cw = ucode(step_q);
	// A finishing step waits until the result register can take its result.
	assign stall = cw.done && out_block;
	assign in_ready = (step_q == U_IDLE);
	assign ctrl = stall ? CTRL_NOP : cw;

	always_comb begin
		step_d = step_q;
		if (!stall) begin
			case (cw.br)
				BR_NEXT:     step_d = step_t'(step_q + 1'b1);
				BR_WAIT:     step_d = in_accept ? step_t'(step_q + 1'b1) : step_q;
				BR_SEL: begin
					if (stat.is_load) begin
						step_d = U_LOAD;
					end else if (stat.long_instr) begin
						step_d = step_t'(step_q + 1'b1);
					end else begin
						step_d = dispatch(stat.op);
					end
				end
				BR_DISPATCH: step_d = dispatch(stat.op);
				BR_GOTO:     step_d = cw.target;
				default:     step_d = U_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= U_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

`ifndef SYNTHESIS
	a_accept_to_sel: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> step_q == U_SEL)
		else $error("accepted item did not move to the select step");
	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.done |=> step_q == U_IDLE)
		else $error("finished instruction did not return to idle");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		stall |=> $stable(step_q))
		else $error("sequencer advanced while the result register was full");
	a_done_unblocked: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.done |-> !out_block)
		else $error("result produced while the result register was blocked");
`endif

endmodule

// ----- rtl/ncpu_dp.sv -----
module ncpu_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_accept,
	input  logic               opcode,
	input  logic [7:0]         load_address,
	input  logic [7:0]         load_data,
	input  ncpu_pkg::ctrl_t    ctrl,
	input  logic [7:0]         rdata,
	output ncpu_pkg::stat_t    stat,
	output ncpu_pkg::mem_req_t mem_req,
	output ncpu_pkg::res_t     res
);
	import ncpu_pkg::*;

	localparam logic [2:0] CMP_ONE   = 3'd0;
	localparam logic [2:0] CMP_ZERO  = 3'd1;
	localparam logic [2:0] CMP_EQUAL = 3'd2;
	localparam logic [2:0] CMP_SIGN  = 3'd3;
	localparam logic [3:0] HIGH_PAGE = 4'hF;

	logic [3:0]  a_q, b_q, a_d, b_d;
	logic [11:0] pc_q, pc_d, pc_inc;
	logic        f_q, f_d;
	logic        item_load_q;
	logic [7:0]  ld_addr_q, ld_data_q;
	logic [7:0]  ir_q;
	logic [3:0]  adr_hi_q;
	logic [3:0]  imm;
	op_t         op;
	logic [7:0]  adr;
	logic [3:0]  add_opd;
	logic [4:0]  sum;
	logic [3:0]  nand_res;
	logic [7:0]  st_data;

	assign imm = ir_q[7:4];
	assign op = op_t'(ir_q[3:0]);
	assign adr = {adr_hi_q, imm};
	assign pc_inc = pc_q + 12'd1;

	assign stat.is_load = item_load_q;
	assign stat.long_instr = is_long(rdata[3:0]);
	assign stat.op = ctrl.ir_ld ? op_t'(rdata[3:0]) : op;

	// Register and immediate forms share one adder and one NAND.
	assign add_opd = (op == OP_ADD_B || op == OP_NAND_B) ? b_q : imm;
	assign sum = {1'b0, a_q} + {1'b0, add_opd} + {4'b0000, f_q};
	assign nand_res = ~(a_q & add_opd);

	always_comb begin
		case (op)
			OP_ST_AB:  st_data = {a_q, b_q};
			OP_ST_PCB: st_data = {pc_q[3:0], b_q};
			OP_ST_BB:  st_data = {b_q, b_q};
			OP_ST_PCH: st_data = pc_q[11:4];
			default:   st_data = 8'h00;
		endcase
	end

	always_comb begin
		mem_req = '0;
		case (ctrl.mem_op)
			MEM_RD_PC: begin
				mem_req.re = 1'b1;
				mem_req.addr = pc_q[7:0];
			end
			MEM_RD_PC1: begin
				mem_req.re = 1'b1;
				mem_req.addr = pc_q[7:0] + 8'd1;
			end
			MEM_RD_HIGH: begin
				mem_req.re = 1'b1;
				mem_req.addr = {HIGH_PAGE, imm};
			end
			MEM_RD_ADR: begin
				mem_req.re = 1'b1;
				mem_req.addr = adr;
			end
			MEM_WR_LOAD: begin
				mem_req.we = 1'b1;
				mem_req.addr = ld_addr_q;
				mem_req.wdata = ld_data_q;
			end
			MEM_WR_STORE: begin
				mem_req.we = 1'b1;
				mem_req.addr = adr;
				mem_req.wdata = st_data;
			end
			default: mem_req = '0;
		endcase
	end

	always_comb begin
		a_d = a_q;
		b_d = b_q;
		f_d = f_q;
		case (ctrl.wb)
			WB_EXEC: begin
				case (op)
					OP_LDI_A:  a_d = imm;
					OP_LDI_B:  b_d = imm;
					OP_ADDI,
					OP_ADD_B: begin
						a_d = sum[3:0];
						f_d = sum[4];
					end
					OP_NANDI,
					OP_NAND_B: a_d = nand_res;
					OP_CMP: begin
						case (imm[2:0])
							CMP_ONE:   f_d = 1'b1;
							CMP_ZERO:  f_d = (a_q == 4'h0);
							CMP_EQUAL: f_d = (a_q == b_q);
							CMP_SIGN:  f_d = a_q[3];
							default:   f_d = f_q;
						endcase
					end
					OP_NCMP: begin
						case (imm[2:0])
							CMP_ONE:   f_d = 1'b0;
							CMP_ZERO:  f_d = (a_q != 4'h0);
							CMP_EQUAL: f_d = (a_q != b_q);
							CMP_SIGN:  f_d = !a_q[3];
							default:   f_d = f_q;
						endcase
					end
					default: begin
						a_d = a_q;
					end
				endcase
			end
			WB_MEM_A: a_d = rdata[7:4];
			WB_MEM_B: b_d = rdata[7:4];
			default:  a_d = a_q;
		endcase
	end

	always_comb begin
		case (ctrl.pc_op)
			PC_INC:       pc_d = pc_inc;
			PC_JUMP:      pc_d = {4'h0, adr};
			PC_JUMP_IF_F: pc_d = f_q ? {4'h0, adr} : pc_inc;
			default:      pc_d = pc_q;
		endcase
	end

	assign res.reg_a = a_d;
	assign res.reg_b = b_d;
	assign res.program_counter = pc_d;
	assign res.cond_flag = f_d;
	assign res.store_valid = ctrl.store;
	assign res.store_address = ctrl.store ? adr : 8'h00;
	assign res.store_data = ctrl.store ? st_data : 8'h00;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= '0;
			b_q <= '0;
			pc_q <= '0;
			f_q <= 1'b0;
			item_load_q <= 1'b0;
		end else begin
			a_q <= a_d;
			b_q <= b_d;
			pc_q <= pc_d;
			f_q <= f_d;
			if (in_accept) begin
				item_load_q <= opcode;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			ld_addr_q <= load_address;
			ld_data_q <= load_data;
		end
		if (ctrl.ir_ld) begin
			ir_q <= rdata;
		end
		if (ctrl.adr_ld) begin
			adr_hi_q <= rdata[3:0];
		end
	end

endmodule

// ----- rtl/nibble_cpu_core.sv -----
// Small 4-bit processor with a 256-byte program and data memory.
// The item channel carries either a memory write (opcode 1), used to load a
// program, or a request to execute one instruction at the current PC
// (opcode 0). Every item produces exactly one transfer on the result channel:
// A, B, PC and the flag after the item, plus the store made by the
// instruction, if any.
// A load item and a one-byte instruction go from the select step straight to
// their final step; jumps and stores first read the second byte and take the
// address from it, and memory loads into A or B then read the data before
// the write-back. The next item is taken in the idle step after the previous
// one's final step; that step also fetches the opcode. No new item is taken
// before the last one is through, as the single memory port serves the
// opcode fetch, the second byte and the data access one after another.
// A finished result waits in an output register; while the receiver stalls,
// the next item can still be taken and run up to its final step, where it
// waits for the register to free up.
// Reset clears A, B, PC, the flag and the memory's valid bits, so every byte
// reads zero until written; no clearing pass is needed.
module nibble_cpu_core #(
	parameter int MEM_DEPTH = 256
) (
	input logic        clk,
	input logic        arst_n,
	ncpu_in_if.sink    item,
	ncpu_out_if.source result
);
	import ncpu_pkg::*;

	logic     in_accept;
	logic     in_ready;
	logic     out_block;
	ctrl_t    ctrl;
	stat_t    stat;
	mem_req_t mem_req;
	logic [7:0] rdata;
	res_t     res;
	res_t     res_q;
	logic     out_valid_q;

	assign item.ready = in_ready;
	assign in_accept = item.valid && in_ready;
	assign out_block = out_valid_q && !result.ready;

	ncpu_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_accept (in_accept),
		.stat      (stat),
		.out_block (out_block),
		.in_ready  (in_ready),
		.ctrl      (ctrl)
	);

	ncpu_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_accept    (in_accept),
		.opcode       (item.opcode),
		.load_address (item.load_address),
		.load_data    (item.load_data),
		.ctrl         (ctrl),
		.rdata        (rdata),
		.stat         (stat),
		.mem_req      (mem_req),
		.res          (res)
	);

	ncpu_mem #(
		.DEPTH (MEM_DEPTH)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mem_req),
		.rdata  (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.done) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.done) begin
			res_q <= res;
		end
	end

	assign result.valid = out_valid_q;
	assign result.reg_a = res_q.reg_a;
	assign result.reg_b = res_q.reg_b;
	assign result.program_counter = res_q.program_counter;
	assign result.cond_flag = res_q.cond_flag;
	assign result.store_valid = res_q.store_valid;
	assign result.store_address = res_q.store_address;
	assign result.store_data = res_q.store_data;

endmodule
